/* hdl/fbat_pkg.sv */
// Shared widths, reset constants and the request token for the flow byte table.
package fbat_pkg;

    localparam int PROTO_W   = 8;
    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 16;
    localparam int BYTES_W   = 32;
    localparam int IDX_OUT_W = 7;

    localparam logic [PROTO_W-1:0] PROTO_RESET = 8'd6;

    // Request token handed from cell to cell along the table.
    typedef struct packed {
        logic               valid;   // token present in this slot
        logic               active;  // protocol matched, table lookup wanted
        logic               done;    // some cell has taken the request
        logic [ADDR_W-1:0]  src;
        logic [ADDR_W-1:0]  dst;
        logic [LEN_W-1:0]   len;
        logic [BYTES_W-1:0] bytes;   // updated total once done
    } tok_t;

endpackage

/* hdl/fbat_if.sv */
// Channel interfaces: packet requests, results and the protocol register write.
interface fbat_pkt_if;
    logic                          valid;
    logic                          ready;
    logic [fbat_pkg::PROTO_W-1:0]  ip_protocol;
    logic [fbat_pkg::ADDR_W-1:0]   src_addr;
    logic [fbat_pkg::ADDR_W-1:0]   dst_addr;
    logic [fbat_pkg::LEN_W-1:0]    cap_len;

    modport source (output valid, ip_protocol, src_addr, dst_addr, cap_len, input ready);
    modport sink   (input valid, ip_protocol, src_addr, dst_addr, cap_len, output ready);
endinterface

interface fbat_res_if;
    logic                            valid;
    logic                            ready;
    logic                            counted;
    logic                            table_full;
    logic [fbat_pkg::IDX_OUT_W-1:0]  flow_index;
    logic [fbat_pkg::BYTES_W-1:0]    flow_bytes;
    logic [fbat_pkg::IDX_OUT_W-1:0]  top_index;
    logic [fbat_pkg::ADDR_W-1:0]     top_src;
    logic [fbat_pkg::ADDR_W-1:0]     top_dst;
    logic [fbat_pkg::BYTES_W-1:0]    top_bytes;

    modport source (output valid, counted, table_full, flow_index, flow_bytes,
                    top_index, top_src, top_dst, top_bytes, input ready);
    modport sink   (input valid, counted, table_full, flow_index, flow_bytes,
                    top_index, top_src, top_dst, top_bytes, output ready);
endinterface

interface fbat_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [fbat_pkg::PROTO_W-1:0]  match_protocol;

    modport source (output valid, match_protocol, input ready);
    modport sink   (input valid, match_protocol, output ready);
endinterface

/* hdl/fbat_cell.sv */
// One table entry: holds a flow pair and its byte total, serves the passing request token.
module fbat_cell #(
    parameter int IDX_W      = 7,
    parameter int CELL_INDEX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fbat_pkg::tok_t   tok_in,
    input  logic [IDX_W-1:0] idx_in,
    output fbat_pkg::tok_t   tok_out,
    output logic [IDX_W-1:0] idx_out
);
    import fbat_pkg::*;

    logic               valid_reg;
    logic [ADDR_W-1:0]  src_reg;
    logic [ADDR_W-1:0]  dst_reg;
    logic [BYTES_W-1:0] bytes_reg;
    tok_t               tok_reg;
    tok_t               tok_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;

    logic               lookup;
    logic               hit;
    logic               alloc;
    logic               take;
    logic [BYTES_W-1:0] base;
    logic [BYTES_W:0]   sum;
    logic [BYTES_W-1:0] sat;

    // Entries fill from the lowest index and are never freed, so the first
    // empty cell reached without a hit is the lowest free entry.
    always_comb
    begin
        lookup   = tok_in.valid && tok_in.active && !tok_in.done;
        hit      = lookup && valid_reg && (src_reg == tok_in.src) && (dst_reg == tok_in.dst);
        alloc    = lookup && !valid_reg;
        take     = hit || alloc;
        base     = hit ? bytes_reg : '0;
        sum      = {1'b0, base} + (BYTES_W+1)'(tok_in.len);
        sat      = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
        tok_next = tok_in;
        idx_next = idx_in;
        if (take)
        begin
            tok_next.done  = 1'b1;
            tok_next.bytes = sat;
            idx_next       = IDX_W'(CELL_INDEX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (take)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (take)
        begin
            src_reg   <= tok_in.src;
            dst_reg   <= tok_in.dst;
            bytes_reg <= sat;
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(valid_reg) |-> valid_reg)
        else $error("table entry lost its valid mark");

    a_done_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_in.valid && tok_in.done) |=> (tok_out.valid && tok_out.done))
        else $error("served request token lost its done mark");

    a_inactive_untouched: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_in.valid && !tok_in.active) |=> (tok_out.valid && !tok_out.done))
        else $error("ignored protocol request was served by an entry");

endmodule

/* hdl/flow_byte_accounting_table_top.sv */
// Flow byte accounting table: chain of entry cells with running top-flow tracking.
//
//  channel  dir  fields                                                   accepted when
//  cfg      in   match_protocol                                           valid && ready
//  pkt      in   ip_protocol, src_addr, dst_addr, cap_len                 valid && ready
//  res      out  counted, table_full, flow_index, flow_bytes,             valid && ready
//                top_index, top_src, top_dst, top_bytes
//
// One request at a time: it walks the cell chain one entry per cycle, from the
// launch slot through the entry cells to the finish register; its result is then
// offered from the output register, and the next request is taken once it retires.
// Reset empties the table (entry valid marks only), protocol resets to 6.
// A stalled result sits in the output register; a finished request waits for
// it to drain before the top flow is updated and the next request is taken.
module flow_byte_accounting_table_top #(
    parameter int TABLE_ENTRIES = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    fbat_cfg_if.sink   cfg,
    fbat_pkt_if.sink   pkt,
    fbat_res_if.source res
);
    import fbat_pkg::*;

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int EXT_W   = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [PROTO_W-1:0]  proto_reg;

    tok_t                launch_reg;
    tok_t                tok_chain [0:TABLE_ENTRIES];
    logic [IDX_W-1:0]    idx_chain [0:TABLE_ENTRIES];

    tok_t                fin_reg;
    logic [IDX_W-1:0]    fin_idx_reg;

    logic [IDX_W-1:0]    best_entry_reg;
    logic [IDX_W-1:0]    best_entry_next;
    logic [BYTES_W-1:0]  best_total_reg;
    logic [BYTES_W-1:0]  best_total_next;
    logic [ADDR_W-1:0]   top_src_reg;
    logic [ADDR_W-1:0]   top_src_next;
    logic [ADDR_W-1:0]   top_dst_reg;
    logic [ADDR_W-1:0]   top_dst_next;

    logic                out_valid_reg;
    logic                out_counted_reg;
    logic                out_full_reg;
    logic [IDX_OUT_W-1:0] out_flow_idx_reg;
    logic [BYTES_W-1:0]  out_flow_bytes_reg;
    logic [IDX_OUT_W-1:0] out_top_idx_reg;
    logic [ADDR_W-1:0]   out_top_src_reg;
    logic [ADDR_W-1:0]   out_top_dst_reg;
    logic [BYTES_W-1:0]  out_top_bytes_reg;

    logic                pkt_take;
    logic                retire;
    logic                new_best;
    logic                pair_update;
    logic [EXT_W-1:0]    fin_idx_ext;
    logic [EXT_W-1:0]    best_idx_ext;

    assign cfg.ready = 1'b1;
    assign pkt.ready = (state_reg == ST_IDLE);
    assign pkt_take  = pkt.valid && (state_reg == ST_IDLE);
    assign retire    = (state_reg == ST_DONE) && (!out_valid_reg || res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proto_reg <= PROTO_RESET;
        end
        else if (cfg.valid)
        begin
            proto_reg <= cfg.match_protocol;
        end
    end

    // Launch slot: a request enters the chain for a single cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg <= '0;
        end
        else
        begin
            launch_reg.valid  <= pkt_take;
            launch_reg.active <= (pkt.ip_protocol == proto_reg);
            launch_reg.done   <= 1'b0;
            launch_reg.src    <= pkt.src_addr;
            launch_reg.dst    <= pkt.dst_addr;
            launch_reg.len    <= pkt.cap_len;
            launch_reg.bytes  <= '0;
        end
    end

    assign tok_chain[0] = launch_reg;
    assign idx_chain[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        fbat_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_chain[g]),
            .idx_in  (idx_chain[g]),
            .tok_out (tok_chain[g+1]),
            .idx_out (idx_chain[g+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pkt_take)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (tok_chain[TABLE_ENTRIES].valid)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (retire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_RUN) && tok_chain[TABLE_ENTRIES].valid)
        begin
            fin_reg     <= tok_chain[TABLE_ENTRIES];
            fin_idx_reg <= idx_chain[TABLE_ENTRIES];
        end
    end

    // Top flow: larger total wins, equal non-zero total moves to the lower index.
    always_comb
    begin
        new_best = fin_reg.done &&
                   ((fin_reg.bytes > best_total_reg) ||
                    ((fin_reg.bytes != '0) && (fin_reg.bytes == best_total_reg) &&
                     (fin_idx_reg < best_entry_reg)));
        // entry 0 supplies the pair while no top flow exists yet
        pair_update = new_best ||
                      (fin_reg.done && (fin_idx_reg == '0) && (best_entry_reg == '0));
        best_entry_next = new_best ? fin_idx_reg   : best_entry_reg;
        best_total_next = new_best ? fin_reg.bytes : best_total_reg;
        top_src_next    = pair_update ? fin_reg.src : top_src_reg;
        top_dst_next    = pair_update ? fin_reg.dst : top_dst_reg;
        fin_idx_ext     = EXT_W'(fin_idx_reg);
        best_idx_ext    = EXT_W'(best_entry_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            best_entry_reg <= '0;
            best_total_reg <= '0;
            top_src_reg    <= '0;
            top_dst_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (retire)
            begin
                best_entry_reg <= best_entry_next;
                best_total_reg <= best_total_next;
                top_src_reg    <= top_src_next;
                top_dst_reg    <= top_dst_next;
                out_valid_reg  <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            out_counted_reg    <= fin_reg.done;
            out_full_reg       <= fin_reg.active && !fin_reg.done;
            out_flow_idx_reg   <= fin_reg.done ? fin_idx_ext[IDX_OUT_W-1:0] : '0;
            out_flow_bytes_reg <= fin_reg.done ? fin_reg.bytes : '0;
            out_top_idx_reg    <= best_idx_ext[IDX_OUT_W-1:0];
            out_top_src_reg    <= top_src_next;
            out_top_dst_reg    <= top_dst_next;
            out_top_bytes_reg  <= best_total_next;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.counted    = out_counted_reg;
    assign res.table_full = out_full_reg;
    assign res.flow_index = out_flow_idx_reg;
    assign res.flow_bytes = out_flow_bytes_reg;
    assign res.top_index  = out_top_idx_reg;
    assign res.top_src    = out_top_src_reg;
    assign res.top_dst    = out_top_dst_reg;
    assign res.top_bytes  = out_top_bytes_reg;

    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        best_total_reg >= $past(best_total_reg))
        else $error("top flow total went down");

    a_no_top_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (best_total_reg == '0) |-> (best_entry_reg == '0))
        else $error("top index moved while no flow has bytes");

    a_chain_exit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        tok_chain[TABLE_ENTRIES].valid |-> (state_reg == ST_RUN))
        else $error("request left the cell chain outside the run state");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_counted_reg && out_full_reg))
        else $error("result marked both counted and table full");

endmodule

/* test/tb_flow_byte_accounting_table_top.sv */
// Self-checking testbench for the flow byte accounting table: directed probes, then random traffic.
module tb_flow_byte_accounting_table_top;
    import fbat_pkg::*;

    localparam int FLOW_SLOTS   = 128;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 3 * FLOW_SLOTS + 200;
    localparam int PHASE_ITEMS  = 286;
    localparam int NUM_PHASES   = 5;
    localparam int NUM_PROBES   = 19;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                 counted;
        logic                 table_full;
        logic [IDX_OUT_W-1:0] flow_index;
        logic [BYTES_W-1:0]   flow_bytes;
        logic [IDX_OUT_W-1:0] top_index;
        logic [ADDR_W-1:0]    top_src;
        logic [ADDR_W-1:0]    top_dst;
        logic [BYTES_W-1:0]   top_bytes;
    } flow_result_t;

    typedef struct packed {
        logic [PROTO_W-1:0] proto;
        logic [ADDR_W-1:0]  src;
        logic [ADDR_W-1:0]  dst;
        logic [LEN_W-1:0]   len;
        logic               known;
        flow_result_t       want;
    } probe_t;

    // typed results only where they follow directly from an empty table
    localparam probe_t PROBES [NUM_PROBES] = '{
        '{8'd17,  32'h00000001, 32'h00000002, 16'd100,   1'b1,
          '{1'b0, 1'b0, 7'd0, 32'd0,     7'd0, 32'h0,        32'h0,        32'd0}},
        '{8'd6,   32'hFFFFFFFF, 32'h00000000, 16'd0,     1'b1,
          '{1'b1, 1'b0, 7'd0, 32'd0,     7'd0, 32'hFFFFFFFF, 32'h0,        32'd0}},
        '{8'd6,   32'h00000000, 32'hFFFFFFFF, 16'd65535, 1'b1,
          '{1'b1, 1'b0, 7'd1, 32'd65535, 7'd1, 32'h0,        32'hFFFFFFFF, 32'd65535}},
        '{8'd6,   32'hFFFFFFFF, 32'h00000000, 16'd65535, 1'b1,
          '{1'b1, 1'b0, 7'd0, 32'd65535, 7'd0, 32'hFFFFFFFF, 32'h0,        32'd65535}},
        '{8'd255, 32'h00000000, 32'h00000000, 16'd1,     1'b1,
          '{1'b0, 1'b0, 7'd0, 32'd0,     7'd0, 32'hFFFFFFFF, 32'h0,        32'd65535}},
        '{8'd0,   32'hFFFFFFFF, 32'hFFFFFFFF, 16'd65535, 1'b1,
          '{1'b0, 1'b0, 7'd0, 32'd0,     7'd0, 32'hFFFFFFFF, 32'h0,        32'd65535}},
        '{8'd6,   32'h00000000, 32'h00000000, 16'd1,     1'b0, '0},
        '{8'd6,   32'h00000000, 32'hFFFFFFFF, 16'd1,     1'b0, '0},
        '{8'd7,   32'h00000000, 32'hFFFFFFFF, 16'd1,     1'b0, '0},
        '{8'd6,   32'hFFFFFFFF, 32'hFFFFFFFF, 16'd100,   1'b0, '0},
        '{8'd6,   32'hFFFFFFFF, 32'h00000001, 16'd0,     1'b0, '0},
        '{8'd6,   32'h00000000, 32'hFFFFFFFF, 16'd0,     1'b0, '0},
        '{8'd6,   32'hA5A5A5A5, 32'h5A5A5A5A, 16'd65535, 1'b0, '0},
        '{8'd6,   32'h5A5A5A5A, 32'hA5A5A5A5, 16'd65535, 1'b0, '0},
        '{8'd6,   32'hA5A5A5A5, 32'h5A5A5A5A, 16'd1,     1'b0, '0},
        '{8'd6,   32'hA5A5A5A5, 32'h5A5A5A5A, 16'd1,     1'b0, '0},
        '{8'd5,   32'hA5A5A5A5, 32'h5A5A5A5A, 16'd1,     1'b0, '0},
        '{8'd6,   32'h12345678, 32'h9ABCDEF0, 16'd32768, 1'b0, '0},
        '{8'd6,   32'hFFFFFFFF, 32'h00000000, 16'd2,     1'b0, '0}
    };

    logic clk;
    logic rst_n;

    fbat_cfg_if cfg ();
    fbat_pkt_if pkt ();
    fbat_res_if res ();

    flow_byte_accounting_table_top #(.TABLE_ENTRIES(FLOW_SLOTS)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .pkt   (pkt),
        .res   (res)
    );

    // shadow of the flow table
    logic [PROTO_W-1:0] match_proto = PROTO_RESET;
    logic               slot_used  [FLOW_SLOTS] = '{default: 1'b0};
    logic [ADDR_W-1:0]  slot_src   [FLOW_SLOTS];
    logic [ADDR_W-1:0]  slot_dst   [FLOW_SLOTS];
    logic [BYTES_W-1:0] slot_bytes [FLOW_SLOTS];
    int                 top_slot   = 0;
    logic [BYTES_W-1:0] top_total  = '0;

    flow_result_t pending_results [$];
    logic [ADDR_W-1:0] seen_src [$];
    logic [ADDR_W-1:0] seen_dst [$];

    bit idle_on = 1'b1;
    int cycle_count = 0;
    int results_seen = 0;
    int fail_count = 0;
    int n_sent = 0;
    int n_counted = 0;
    int n_full = 0;
    int n_ignored = 0;
    int n_flows = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic flow_result_t account_packet(input logic [PROTO_W-1:0] proto,
                                                    input logic [ADDR_W-1:0] src,
                                                    input logic [ADDR_W-1:0] dst,
                                                    input logic [LEN_W-1:0] len);
        flow_result_t r;
        int hit;
        logic [BYTES_W:0] sum;
        r = '0;
        hit = -1;
        if (proto != match_proto)
            n_ignored++;
        else
        begin
            for (int i = 0; i < FLOW_SLOTS; i++)
                if (hit < 0 && slot_used[i] && slot_src[i] == src && slot_dst[i] == dst)
                    hit = i;
            if (hit < 0)
            begin
                for (int i = 0; i < FLOW_SLOTS; i++)
                    if (hit < 0 && !slot_used[i])
                        hit = i;
                if (hit >= 0)
                begin
                    slot_used[hit]  = 1'b1;
                    slot_src[hit]   = src;
                    slot_dst[hit]   = dst;
                    slot_bytes[hit] = '0;
                    n_flows++;
                end
            end
            if (hit < 0)
            begin
                r.table_full = 1'b1;
                n_full++;
            end
            else
            begin
                sum = {1'b0, slot_bytes[hit]} + (BYTES_W + 1)'(len);
                slot_bytes[hit] = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
                // a zero total never takes the top; ties go to the lower slot
                if (slot_bytes[hit] > top_total ||
                    (slot_bytes[hit] != '0 && slot_bytes[hit] == top_total && hit < top_slot))
                begin
                    top_total = slot_bytes[hit];
                    top_slot  = hit;
                end
                r.counted    = 1'b1;
                r.flow_index = IDX_OUT_W'(hit);
                r.flow_bytes = slot_bytes[hit];
                n_counted++;
            end
        end
        r.top_index = IDX_OUT_W'(top_slot);
        if (slot_used[top_slot])
        begin
            r.top_src = slot_src[top_slot];
            r.top_dst = slot_dst[top_slot];
        end
        r.top_bytes = top_total;
        return r;
    endfunction

    task automatic send_packet(input logic [PROTO_W-1:0] proto, input logic [ADDR_W-1:0] src,
                               input logic [ADDR_W-1:0] dst, input logic [LEN_W-1:0] len,
                               input logic known, input flow_result_t want);
        flow_result_t predicted;
        pkt.valid       <= 1'b1;
        pkt.ip_protocol <= proto;
        pkt.src_addr    <= src;
        pkt.dst_addr    <= dst;
        pkt.cap_len     <= len;
        do
            @(posedge clk);
        while (!pkt.ready);
        predicted = account_packet(proto, src, dst, len);
        pending_results.push_back(known ? want : predicted);
        n_sent++;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            pkt.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_drained;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_match_protocol(input logic [PROTO_W-1:0] value);
        cfg.valid          <= 1'b1;
        cfg.match_protocol <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        match_proto = value;
    endtask

    // result side: random back-pressure plus one long hold to fill the pipeline
    initial
    begin : drain_results
        bit long_hold_done;
        long_hold_done = 1'b0;
        res.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && results_seen >= 40)
            begin
                long_hold_done = 1'b1;
                res.ready <= 1'b0;
                for (int n = 0; n < LONG_HOLD; n++)
                    @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            res.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        flow_result_t got;
        flow_result_t want;
        if (rst_n && res.valid && res.ready)
        begin
            got = {res.counted, res.table_full, res.flow_index, res.flow_bytes,
                   res.top_index, res.top_src, res.top_dst, res.top_bytes};
            results_seen++;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("cycle %0d: result with no request pending", cycle_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.counted !== want.counted || got.table_full !== want.table_full ||
                    got.flow_index !== want.flow_index || got.flow_bytes !== want.flow_bytes ||
                    got.top_index !== want.top_index || got.top_src !== want.top_src ||
                    got.top_dst !== want.top_dst || got.top_bytes !== want.top_bytes)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("cycle %0d: result %0d mismatch", cycle_count, results_seen);
                        $display("  exp cnt=%0d full=%0d idx=%0d bytes=%0d top=%0d %h/%h %0d",
                                 want.counted, want.table_full, want.flow_index,
                                 want.flow_bytes, want.top_index, want.top_src,
                                 want.top_dst, want.top_bytes);
                        $display("  got cnt=%0d full=%0d idx=%0d bytes=%0d top=%0d %h/%h %0d",
                                 got.counted, got.table_full, got.flow_index,
                                 got.flow_bytes, got.top_index, got.top_src,
                                 got.top_dst, got.top_bytes);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [PROTO_W-1:0] phase_proto [NUM_PHASES];
        logic [PROTO_W-1:0] proto;
        logic [ADDR_W-1:0]  src;
        logic [ADDR_W-1:0]  dst;
        logic [LEN_W-1:0]   len;
        int phase_sent;
        int pick;
        int span;

        rst_n              = 1'b0;
        pkt.valid          = 1'b0;
        pkt.ip_protocol    = '0;
        pkt.src_addr       = '0;
        pkt.dst_addr       = '0;
        pkt.cap_len        = '0;
        cfg.valid          = 1'b0;
        cfg.match_protocol = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < NUM_PROBES; p++)
            send_packet(PROBES[p].proto, PROBES[p].src, PROBES[p].dst, PROBES[p].len,
                        PROBES[p].known, PROBES[p].want);
        pkt.valid <= 1'b0;
        wait_drained();

        phase_proto = '{8'd0, 8'd255, 8'd17, PROTO_W'($urandom_range(1, 254)), PROTO_RESET};
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // one quiet stretch mid-run, and none at all in the last phase
            idle_on = (ph != 2 && ph != NUM_PHASES - 1);
            set_match_protocol(phase_proto[ph]);
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS)
            begin
                proto = ($urandom_range(0, 99) < 15) ? PROTO_W'($urandom) : match_proto;
                pick = $urandom_range(0, 99);
                if (seen_src.size() == 0 || pick < 28)
                begin
                    src = $urandom;
                    dst = $urandom;
                    if ($urandom_range(0, 7) == 0)
                        src = ($urandom_range(0, 1) != 0) ? '1 : '0;
                    if ($urandom_range(0, 7) == 0)
                        dst = ($urandom_range(0, 1) != 0) ? '1 : '0;
                    seen_src.push_back(src);
                    seen_dst.push_back(dst);
                end
                else if (pick < 36)
                begin
                    // same source, new destination: must not hit
                    src = seen_src[$urandom_range(0, seen_src.size() - 1)];
                    dst = $urandom;
                    seen_src.push_back(src);
                    seen_dst.push_back(dst);
                end
                else
                begin
                    // favour early pairs, which are the ones most likely in the table
                    span = (seen_src.size() < 160) ? seen_src.size() : 160;
                    pick = $urandom_range(0, span - 1);
                    src = seen_src[pick];
                    dst = seen_dst[pick];
                end
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    len = '0;
                else if (pick < 16)
                    len = '1;
                else
                    len = LEN_W'($urandom);
                send_packet(proto, src, dst, len, 1'b0, '0);
                phase_sent++;
            end
            pkt.valid <= 1'b0;
            wait_drained();
        end

        repeat (FLOW_SLOTS + 8) @(posedge clk);
        $display("%0d packets, %0d protocol settings: %0d counted, %0d table full, %0d ignored",
                 n_sent, NUM_PHASES + 1, n_counted, n_full, n_ignored);
        $display("%0d flows allocated, top flow %0d at %0d bytes, %0d results checked",
                 n_flows, top_slot, top_total, results_seen);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
hdl/fbat_pkg.sv
hdl/fbat_if.sv
hdl/fbat_cell.sv
hdl/flow_byte_accounting_table_top.sv
test/tb_flow_byte_accounting_table_top.sv
